// File: hdl/greedy_line_wrap_defines.svh
// ----------------------------------------------------------------------------
// Greedy line wrap assertion macros
// Shared property shapes for the checkers of the line wrap block.
// ----------------------------------------------------------------------------
`ifndef GREEDY_LINE_WRAP_DEFINES_SVH
`define GREEDY_LINE_WRAP_DEFINES_SVH

// Consequent is checked in the cycle after the antecedent, outside reset.
`define GLW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Same shape, but also checked while reset is held.
`define GLW_ASSERT_ALWAYS_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/glw_pkg.sv
// ----------------------------------------------------------------------------
// Greedy line wrap package
// Character codes, configuration register map and shared types.
// ----------------------------------------------------------------------------
package glw_pkg;

  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_TAB   = 8'd9;

  localparam int CFG_INDEX_BITS  = 2;
  localparam int CFG_DATA_BITS   = 24;
  localparam int WRAP_WIDTH_BITS = 16;

  localparam logic [WRAP_WIDTH_BITS-1:0] WRAP_WIDTH_RESET = '1;

  // One item can start at most this many new lines.
  localparam int MAX_BREAKS       = 3;
  localparam int BREAK_COUNT_BITS = 2;

  // Entries in the queue between the wrap engine and the output stage.
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_WRAP_ENABLE = 2'd0,
    REG_WRAP_WIDTH  = 2'd1,
    REG_START_POS   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic                     write;
    cfg_reg_t                 index;
    logic [CFG_DATA_BITS-1:0] data;
  } cfg_write_t;

endpackage

// File: hdl/glw_char_if.sv
// ----------------------------------------------------------------------------
// Character channel
// Valid/ready channel carrying one character and its glyph width per item.
// ----------------------------------------------------------------------------
interface glw_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic [7:0] char_width;
  logic       last_char;

  modport source (output valid, char_code, char_width, last_char, input ready);
  modport sink (input valid, char_code, char_width, last_char, output ready);
endinterface

// File: hdl/glw_break_if.sv
// ----------------------------------------------------------------------------
// Line break channel
// Valid/ready channel carrying one line start position per item.
// ----------------------------------------------------------------------------
interface glw_break_if #(
  parameter int POSITION_BITS = 24
);
  logic                     valid;
  logic                     ready;
  logic [POSITION_BITS-1:0] break_pos;
  logic                     run_end;

  modport source (output valid, break_pos, run_end, input ready);
  modport sink (input valid, break_pos, run_end, output ready);
endinterface

// File: hdl/glw_queue.sv
// ----------------------------------------------------------------------------
// Break record queue
// Small flop-based FIFO between the wrap engine and the output stage.
// ----------------------------------------------------------------------------
module glw_queue #(
  parameter int DATA_BITS = 74
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [DATA_BITS-1:0] push_data,
  output logic                 ready,
  output logic                 valid,
  input  logic                 pop,
  output logic [DATA_BITS-1:0] head_data
);

  localparam int PTR_BITS = $clog2(glw_pkg::QUEUE_DEPTH);

  logic [DATA_BITS-1:0] store [glw_pkg::QUEUE_DEPTH];
  logic [PTR_BITS-1:0]  wr_ptr;
  logic [PTR_BITS-1:0]  rd_ptr;
  logic [PTR_BITS:0]    count;

  assign ready     = count != (PTR_BITS + 1)'(glw_pkg::QUEUE_DEPTH);
  assign valid     = count != '0;
  assign head_data = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + (PTR_BITS + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (PTR_BITS + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_data;
    end
  end

endmodule

// File: hdl/glw_front.sv
// ----------------------------------------------------------------------------
// Greedy line wrap engine
// Accepts characters, classifies them, tracks the line state and produces
// the list of line starts that each character causes.
// ----------------------------------------------------------------------------
module glw_front #(
  parameter int POSITION_BITS = 24,
  parameter int WIDTH_BITS    = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  glw_pkg::cfg_write_t                   cfg,
  glw_char_if.sink                              chars,
  input  logic                                  queue_ready,
  output logic                                  push,
  output logic [glw_pkg::BREAK_COUNT_BITS-1:0]  push_count,
  output logic [glw_pkg::MAX_BREAKS-1:0][POSITION_BITS-1:0] push_pos
);

  localparam int SUM_BITS = (WIDTH_BITS > glw_pkg::WRAP_WIDTH_BITS ?
                             WIDTH_BITS : glw_pkg::WRAP_WIDTH_BITS) + 1;

  // Configuration registers.
  logic                                  wrap_enable;
  logic [glw_pkg::WRAP_WIDTH_BITS-1:0]   wrap_width;
  logic [POSITION_BITS-1:0]              start_pos;

  // Line state.
  logic [POSITION_BITS-1:0]              position;
  logic                                  pending_cr;
  logic [WIDTH_BITS-1:0]                 line_width;
  logic [WIDTH_BITS-1:0]                 tail_width;
  logic                                  has_bp;
  logic [POSITION_BITS-1:0]              bp_pos;

  logic [POSITION_BITS-1:0]              position_next;
  logic                                  pending_cr_next;
  logic [WIDTH_BITS-1:0]                 line_width_next;
  logic [WIDTH_BITS-1:0]                 tail_width_next;
  logic                                  has_bp_next;
  logic [POSITION_BITS-1:0]              bp_pos_next;

  logic                                  accept;
  logic                                  is_cr;
  logic                                  is_lf;
  logic                                  is_ws;
  logic                                  done;
  logic [WIDTH_BITS-1:0]                 lw1;
  logic [WIDTH_BITS-1:0]                 tail1;
  logic                                  has1;
  logic [POSITION_BITS-1:0]              bp1;
  logic [POSITION_BITS-1:0]              pos_inc;
  logic [POSITION_BITS-1:0]              bp_inc;
  logic [SUM_BITS-1:0]                   sum_line;
  logic [SUM_BITS-1:0]                   sum_tail;
  logic [SUM_BITS-1:0]                   limit;
  logic [WIDTH_BITS-1:0]                 sat_line;
  logic [WIDTH_BITS-1:0]                 sat_tail;
  logic [WIDTH_BITS-1:0]                 glyph;
  logic                                  fit_line;
  logic                                  fit_tail;
  logic                                  fit_empty;
  logic [glw_pkg::BREAK_COUNT_BITS-1:0]  n;
  logic [glw_pkg::MAX_BREAKS-1:0][POSITION_BITS-1:0] brk;

  assign accept      = chars.valid && chars.ready;
  assign chars.ready = queue_ready;

  assign is_cr = chars.char_code == glw_pkg::CH_CR;
  assign is_lf = chars.char_code == glw_pkg::CH_LF;
  assign is_ws = chars.char_code == glw_pkg::CH_SPACE ||
                 chars.char_code == glw_pkg::CH_TAB;

  // A held CR that is not followed by LF ends its line before this item,
  // so the item then sees an empty line.
  assign lw1   = pending_cr ? '0 : line_width;
  assign tail1 = pending_cr ? '0 : tail_width;
  assign has1  = pending_cr ? 1'b0 : has_bp;
  assign bp1   = pending_cr ? '0 : bp_pos;

  assign pos_inc = position + POSITION_BITS'(1);
  assign bp_inc  = bp1 + POSITION_BITS'(1);
  assign glyph   = WIDTH_BITS'(chars.char_width);

  assign sum_line = SUM_BITS'(lw1) + SUM_BITS'(chars.char_width);
  assign sum_tail = SUM_BITS'(tail1) + SUM_BITS'(chars.char_width);
  assign limit    = SUM_BITS'(wrap_width);

  assign fit_line  = !wrap_enable || sum_line <= limit;
  assign fit_tail  = !wrap_enable || sum_tail <= limit;
  assign fit_empty = !wrap_enable || SUM_BITS'(chars.char_width) <= limit;

  // Widths saturate at the all-ones value of the width registers.
  assign sat_line = sum_line[WIDTH_BITS] ? '1 : sum_line[WIDTH_BITS-1:0];
  assign sat_tail = sum_tail[WIDTH_BITS] ? '1 : sum_tail[WIDTH_BITS-1:0];

  always_comb begin
    n               = '0;
    brk             = '0;
    done            = 1'b0;
    pending_cr_next = 1'b0;
    line_width_next = lw1;
    tail_width_next = tail1;
    has_bp_next     = has1;
    bp_pos_next     = bp1;

    if (pending_cr) begin
      if (is_lf) begin
        brk[n] = pos_inc;
        n      = n + 2'd1;
        done   = 1'b1;
      end else begin
        brk[n] = position;
        n      = n + 2'd1;
      end
    end

    if (!done) begin
      if (is_cr) begin
        if (chars.last_char) begin
          brk[n] = pos_inc;
          n      = n + 2'd1;
        end else begin
          pending_cr_next = 1'b1;
        end
      end else if (is_lf) begin
        brk[n]          = pos_inc;
        n               = n + 2'd1;
        line_width_next = '0;
        tail_width_next = '0;
        has_bp_next     = 1'b0;
        bp_pos_next     = '0;
      end else if (fit_line) begin
        line_width_next = sat_line;
        tail_width_next = is_ws ? '0 : sat_tail;
        has_bp_next     = is_ws || has1;
        bp_pos_next     = is_ws ? position : bp1;
      end else if (lw1 == '0) begin
        // A glyph wider than the limit stands alone on its line.
        brk[n]          = pos_inc;
        n               = n + 2'd1;
        line_width_next = '0;
        tail_width_next = '0;
        has_bp_next     = 1'b0;
        bp_pos_next     = '0;
      end else if (is_ws || !has1) begin
        // Break before this character, then retry it on an empty line.
        brk[n] = position;
        n      = n + 2'd1;
        if (fit_empty) begin
          line_width_next = glyph;
          tail_width_next = is_ws ? '0 : glyph;
          has_bp_next     = is_ws;
          bp_pos_next     = is_ws ? position : '0;
        end else begin
          brk[n]          = pos_inc;
          n               = n + 2'd1;
          line_width_next = '0;
          tail_width_next = '0;
          has_bp_next     = 1'b0;
          bp_pos_next     = '0;
        end
      end else begin
        // Break after the last space; the trailing word moves down.
        brk[n]      = bp_inc;
        n           = n + 2'd1;
        has_bp_next = 1'b0;
        bp_pos_next = '0;
        if (fit_tail) begin
          line_width_next = sat_tail;
          tail_width_next = sat_tail;
        end else if (tail1 == '0) begin
          brk[n]          = pos_inc;
          n               = n + 2'd1;
          line_width_next = '0;
          tail_width_next = '0;
        end else begin
          brk[n] = position;
          n      = n + 2'd1;
          if (fit_empty) begin
            line_width_next = glyph;
            tail_width_next = glyph;
          end else begin
            brk[n]          = pos_inc;
            n               = n + 2'd1;
            line_width_next = '0;
            tail_width_next = '0;
          end
        end
      end
    end

    position_next = pos_inc;
    if (chars.last_char) begin
      position_next   = start_pos;
      pending_cr_next = 1'b0;
      line_width_next = '0;
      tail_width_next = '0;
      has_bp_next     = 1'b0;
      bp_pos_next     = '0;
    end
  end

  assign push       = accept && n != '0;
  assign push_count = n;
  assign push_pos   = brk;

  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_enable <= 1'b1;
      wrap_width  <= glw_pkg::WRAP_WIDTH_RESET;
      start_pos   <= '0;
      position    <= '0;
      pending_cr  <= 1'b0;
      line_width  <= '0;
      tail_width  <= '0;
      has_bp      <= 1'b0;
      bp_pos      <= '0;
    end else begin
      if (accept) begin
        position   <= position_next;
        pending_cr <= pending_cr_next;
        line_width <= line_width_next;
        tail_width <= tail_width_next;
        has_bp     <= has_bp_next;
        bp_pos     <= bp_pos_next;
      end
      if (cfg.write) begin
        case (cfg.index)
          glw_pkg::REG_WRAP_ENABLE: begin
            wrap_enable <= cfg.data[0];
          end
          glw_pkg::REG_WRAP_WIDTH: begin
            wrap_width <= cfg.data[glw_pkg::WRAP_WIDTH_BITS-1:0];
          end
          glw_pkg::REG_START_POS: begin
            start_pos <= POSITION_BITS'(cfg.data);
            position  <= POSITION_BITS'(cfg.data);
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// File: hdl/glw_emit.sv
// ----------------------------------------------------------------------------
// Line break output stage
// Unrolls each queued break record onto the output channel, one line start
// per item, and marks the last one of each record.
// ----------------------------------------------------------------------------
module glw_emit #(
  parameter int POSITION_BITS = 24
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  head_valid,
  input  logic [glw_pkg::BREAK_COUNT_BITS-1:0]  head_count,
  input  logic [glw_pkg::MAX_BREAKS-1:0][POSITION_BITS-1:0] head_pos,
  output logic                                  pop,
  glw_break_if.source                           breaks
);

  logic                                  out_valid;
  logic [POSITION_BITS-1:0]              out_pos;
  logic                                  out_end;
  logic [glw_pkg::BREAK_COUNT_BITS-1:0]  idx;
  logic                                  load;
  logic                                  last_of_record;

  assign load           = head_valid && (!out_valid || breaks.ready);
  assign last_of_record = (idx + 2'd1) == head_count;
  assign pop            = load && last_of_record;

  assign breaks.valid     = out_valid;
  assign breaks.break_pos = out_pos;
  assign breaks.run_end   = out_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= last_of_record ? '0 : idx + 2'd1;
    end else if (breaks.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_pos <= head_pos[idx];
      out_end <= last_of_record;
    end
  end

endmodule

// File: hdl/greedy_line_wrap.sv
// ----------------------------------------------------------------------------
// Greedy line wrap
// Streams characters with glyph widths and emits the positions where new
// lines start.
// ----------------------------------------------------------------------------
// The block takes one character per clock as long as its four-entry break
// queue has room; an item that starts no new line takes no queue entry.
// Each character starts zero to three lines, and the output channel
// delivers one line start per clock from a registered stage while the
// receiver is ready, so with dense breaks the output side sets the pace.
// The first line start of an item passes through the queue and then the
// output register. All wrap state is updated in the accepting cycle by a
// single add-and-compare step, so the next item can follow at once.
// Writing start_pos also reloads the running position; after an item
// marked as the last character the line state returns to its reset values
// and the position restarts at start_pos.
module greedy_line_wrap #(
  parameter int POSITION_BITS = 24,
  parameter int WIDTH_BITS    = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [glw_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [glw_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  glw_char_if.sink                            chars,
  glw_break_if.source                         breaks
);

  localparam int REC_BITS = glw_pkg::BREAK_COUNT_BITS +
                            glw_pkg::MAX_BREAKS * POSITION_BITS;

  glw_pkg::cfg_write_t                          cfg;
  logic                                         push;
  logic [glw_pkg::BREAK_COUNT_BITS-1:0]         push_count;
  logic [glw_pkg::MAX_BREAKS-1:0][POSITION_BITS-1:0] push_pos;
  logic                                         queue_ready;
  logic                                         head_valid;
  logic                                         pop;
  logic [REC_BITS-1:0]                          head_data;
  logic [glw_pkg::BREAK_COUNT_BITS-1:0]         head_count;
  logic [glw_pkg::MAX_BREAKS-1:0][POSITION_BITS-1:0] head_pos;

  assign cfg.write = cfg_write;
  assign cfg.index = glw_pkg::cfg_reg_t'(cfg_index);
  assign cfg.data  = cfg_data;

  glw_front #(
    .POSITION_BITS (POSITION_BITS),
    .WIDTH_BITS    (WIDTH_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .chars       (chars),
    .queue_ready (queue_ready),
    .push        (push),
    .push_count  (push_count),
    .push_pos    (push_pos)
  );

  glw_queue #(
    .DATA_BITS (REC_BITS)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_count, push_pos}),
    .ready     (queue_ready),
    .valid     (head_valid),
    .pop       (pop),
    .head_data (head_data)
  );

  assign head_count = head_data[REC_BITS-1 -: glw_pkg::BREAK_COUNT_BITS];
  assign head_pos   = head_data[glw_pkg::MAX_BREAKS*POSITION_BITS-1:0];

  glw_emit #(
    .POSITION_BITS (POSITION_BITS)
  ) u_emit (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_count (head_count),
    .head_pos   (head_pos),
    .pop        (pop),
    .breaks     (breaks)
  );

endmodule

// File: hdl/glw_port_checker.sv
// ----------------------------------------------------------------------------
// Greedy line wrap port checker
// Watches the ports of the line wrap block and flags misbehavior over time.
// ----------------------------------------------------------------------------
`include "greedy_line_wrap_defines.svh"

module glw_port_checker #(
  parameter int POSITION_BITS = 24
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic                     run_end,
  input logic [POSITION_BITS-1:0] break_pos
);

  // Reset empties the output stage and the queue.
  `GLW_ASSERT_ALWAYS_NEXT(a_reset_no_output, rst, !out_valid, "output valid after reset")
  `GLW_ASSERT_ALWAYS_NEXT(a_reset_ready, rst, in_ready, "input not ready after reset")

  // The rest of a record is already queued, so it follows without a gap.
  `GLW_ASSERT_NEXT(a_record_contiguous, out_valid && out_ready && !run_end, out_valid, "gap inside a break record")

  `GLW_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(break_pos) && $stable(run_end), "stalled break changed")

endmodule

bind greedy_line_wrap glw_port_checker #(
  .POSITION_BITS (POSITION_BITS)
) u_port_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (chars.ready),
  .out_valid (breaks.valid),
  .out_ready (breaks.ready),
  .run_end   (breaks.run_end),
  .break_pos (breaks.break_pos)
);
